// ===== rtl/core/sdi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared widths, codes and types of the Sellmeier dispersion index pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sdi_pkg;

  localparam int NumTerms   = 3;
  localparam int WaveWidth  = 24;
  localparam int L2Width    = 48;
  localparam int CoefWidth  = 32;
  localparam int DmagWidth  = 50;
  localparam int NumWidth   = 91;
  localparam int SumWidth   = 94;
  localparam int RadWidth   = 64;
  localparam int RootWidth  = 32;
  localparam int IndexWidth = 3;
  localparam int StatWidth  = 2;

  localparam logic [StatWidth-1:0] ST_OK   = 2'd0;
  localparam logic [StatWidth-1:0] ST_POLE = 2'd1;
  localparam logic [StatWidth-1:0] ST_NEG  = 2'd2;

  localparam logic [IndexWidth-1:0] REG_STRENGTH_ONE    = 3'd0;
  localparam logic [IndexWidth-1:0] REG_STRENGTH_TWO    = 3'd1;
  localparam logic [IndexWidth-1:0] REG_STRENGTH_THREE  = 3'd2;
  localparam logic [IndexWidth-1:0] REG_RESONANCE_ONE   = 3'd3;
  localparam logic [IndexWidth-1:0] REG_RESONANCE_TWO   = 3'd4;
  localparam logic [IndexWidth-1:0] REG_RESONANCE_THREE = 3'd5;

  typedef struct packed {
    logic [NumWidth-1:0]  num;
    logic [DmagWidth-1:0] dmag;
    logic                 neg;
    logic                 pole;
  } term_t;

endpackage

`default_nettype wire

// ===== rtl/core/sdi_front.sv =====
// ----------------------------------------------------------------------------
// sdi_front
// Square the wavelength, form the denominators and the numerators of the
// three terms over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sdi_front (
  input  wire logic                                                 clk,
  input  wire logic                                                 rst,
  input  wire logic                                                 en,
  input  wire logic                                                 in_valid,
  input  wire logic [sdi_pkg::WaveWidth-1:0]                        wavelength,
  input  wire logic [sdi_pkg::NumTerms-1:0][sdi_pkg::CoefWidth-1:0] strength,
  input  wire logic [sdi_pkg::NumTerms-1:0][sdi_pkg::CoefWidth-1:0] resonance,
  output sdi_pkg::term_t [sdi_pkg::NumTerms-1:0]                    term,
  output logic                                                      term_valid
);
  import sdi_pkg::*;

  logic                 v1, v2;
  logic [L2Width-1:0]   l2;
  logic [NumTerms-1:0][DmagWidth-1:0] dmag2;
  logic [NumTerms-1:0]                neg2, pole2;
  logic [NumTerms-1:0][55:0]          plo2, phi2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      term_valid <= 1'b0;
    end else if (en) begin
      v1         <= in_valid;
      v2         <= v1;
      term_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l2 <= wavelength * wavelength;
    end
  end

  for (genvar t = 0; t < NumTerms; t++) begin : g_term
    logic signed [DmagWidth:0] d;
    logic [CoefWidth-1:0]      bmag;
    logic [79:0]               prod;

    assign d    = $signed({3'b000, l2}) - $signed({resonance[t][CoefWidth-1],
                                                   resonance[t], 18'd0});
    assign bmag = strength[t][CoefWidth-1] ? (~strength[t] + 32'd1) : strength[t];
    assign prod = {phi2[t], 24'd0} + {24'd0, plo2[t]};

    always_ff @(posedge clk) begin
      if (en) begin
        dmag2[t]      <= d[DmagWidth] ? DmagWidth'(-d) : d[DmagWidth-1:0];
        neg2[t]       <= strength[t][CoefWidth-1] ^ d[DmagWidth];
        pole2[t]      <= (d == '0);
        plo2[t]       <= bmag * l2[23:0];
        phi2[t]       <= bmag * l2[47:24];
        term[t].num   <= {prod[78:0], 12'd0};
        term[t].dmag  <= dmag2[t];
        term[t].neg   <= neg2[t];
        term[t].pole  <= pole2[t];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sdi_div.sv =====
// ----------------------------------------------------------------------------
// sdi_div
// Three restoring dividers side by side, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sdi_div (
  input  wire logic                                                clk,
  input  wire logic                                                rst,
  input  wire logic                                                en,
  input  wire sdi_pkg::term_t [sdi_pkg::NumTerms-1:0]              term,
  input  wire logic                                                term_valid,
  output logic [sdi_pkg::NumTerms-1:0][sdi_pkg::NumWidth-1:0]      quot,
  output logic [sdi_pkg::NumTerms-1:0]                             quot_neg,
  output logic                                                     quot_pole,
  output logic                                                     quot_valid
);
  import sdi_pkg::*;

  localparam int NB = NumWidth;

  logic [DmagWidth-1:0] rem [0:NB][NumTerms];
  logic [NB-1:0]        nq  [0:NB][NumTerms];
  logic [DmagWidth-1:0] dm  [0:NB][NumTerms];
  logic                 ng  [0:NB][NumTerms];
  logic                 pole [0:NB];
  logic                 vld  [0:NB];

  for (genvar t = 0; t < NumTerms; t++) begin : g_load
    assign rem[0][t] = '0;
    assign nq[0][t]  = term[t].num;
    assign dm[0][t]  = term[t].dmag;
    assign ng[0][t]  = term[t].neg;
    assign quot[t]     = nq[NB][t];
    assign quot_neg[t] = ng[NB][t];
  end

  assign pole[0]    = term[0].pole | term[1].pole | term[2].pole;
  assign vld[0]     = term_valid;
  assign quot_pole  = pole[NB];
  assign quot_valid = vld[NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    for (genvar t = 0; t < NumTerms; t++) begin : g_term
      logic [DmagWidth:0] trial, diff;
      logic               take;

      assign trial = {rem[k][t], nq[k][t][NB-1]};
      assign take  = trial >= {1'b0, dm[k][t]};
      assign diff  = trial - {1'b0, dm[k][t]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1][t] <= take ? diff[DmagWidth-1:0] : trial[DmagWidth-1:0];
          nq[k+1][t]  <= {nq[k][t][NB-2:0], take};
          dm[k+1][t]  <= dm[k][t];
          ng[k+1][t]  <= ng[k][t];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pole[k+1] <= pole[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sdi_root.sv =====
// ----------------------------------------------------------------------------
// sdi_root
// Sum the quotients into the radicand, classify it, and take the square
// root one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sdi_root (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire logic                                            en,
  input  wire logic [sdi_pkg::NumTerms-1:0][sdi_pkg::NumWidth-1:0] quot,
  input  wire logic [sdi_pkg::NumTerms-1:0]                    quot_neg,
  input  wire logic                                            quot_pole,
  input  wire logic                                            quot_valid,
  output logic [sdi_pkg::RootWidth-1:0]                        refractive_index,
  output logic [sdi_pkg::StatWidth-1:0]                        status,
  output logic                                                 out_valid
);
  import sdi_pkg::*;

  localparam int NS = RootWidth;

  logic [NumTerms-1:0][SumWidth-1:0] sq;
  logic [SumWidth-1:0]  sa0, sa1, rad;
  logic                 va, vb, pa;
  logic [RadWidth-1:0]  xs   [0:NS];
  logic [RootWidth:0]   rem  [0:NS];
  logic [RootWidth-1:0] root [0:NS];
  logic [StatWidth-1:0] st   [0:NS];
  logic                 sat  [0:NS];
  logic                 vs   [0:NS];

  for (genvar t = 0; t < NumTerms; t++) begin : g_sign
    assign sq[t] = quot_neg[t] ? (~{3'b000, quot[t]} + SumWidth'(1)) : {3'b000, quot[t]};
  end

  assign rad = sa0 + sa1;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= quot_valid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa0 <= sq[0] + sq[1];
      sa1 <= sq[2] + (SumWidth'(1) << 40);
      pa  <= quot_pole;
      xs[0]   <= {rad[47:0], 16'd0};
      sat[0]  <= (rad[SumWidth-1:48] != '0);
      if (pa) begin
        st[0] <= ST_POLE;
      end else if (rad[SumWidth-1]) begin
        st[0] <= ST_NEG;
      end else begin
        st[0] <= ST_OK;
      end
    end
  end

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign vs[0]   = vb;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [RootWidth+2:0] trial, cmp, diff;
    logic                 take;

    assign trial = {rem[k], xs[k][RadWidth-1:RadWidth-2]};
    assign cmp   = {1'b0, root[k], 2'b01};
    assign take  = trial >= cmp;
    assign diff  = trial - cmp;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? diff[RootWidth:0] : trial[RootWidth:0];
        root[k+1] <= {root[k][RootWidth-2:0], take};
        xs[k+1]   <= {xs[k][RadWidth-3:0], 2'b00};
        st[k+1]   <= st[k];
        sat[k+1]  <= sat[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k+1] <= 1'b0;
      end else if (en) begin
        vs[k+1] <= vs[k];
      end
    end
  end

  assign out_valid = vs[NS];
  assign status    = st[NS];

  always_comb begin
    if (st[NS] != ST_OK) begin
      refractive_index = '0;
    end else if (sat[NS]) begin
      refractive_index = '1;
    end else begin
      refractive_index = root[NS];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sellmeier_dispersion_index.sv =====
// ----------------------------------------------------------------------------
// sellmeier_dispersion_index
// Three-term Sellmeier refractive index, n = sqrt(1 + sum b*l2/(l2 - c)).
//
// Input channel in_valid/in_ready carries one wavelength (Q4.20 um) per
// transfer; output channel out_valid/out_ready carries the index (Q4.28)
// and a status code. The six coefficients are written through
// cfg_write/cfg_index/cfg_data; the user must do so only while no item is in
// flight, which the block does not enforce. It has 3 front stages (square,
// products, numerators), 91 divider stages (one quotient bit per stage), 2
// summing stages and 32 root stages (one root bit per stage). One transfer
// per cycle is sustained unless the receiver stalls with a result waiting;
// then the whole pipeline holds and in_ready drops; nothing is lost or
// repeated. Reset clears the coefficients to zero and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module sellmeier_dispersion_index (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [sdi_pkg::IndexWidth-1:0]  cfg_index,
  input  wire logic [sdi_pkg::CoefWidth-1:0]   cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [sdi_pkg::WaveWidth-1:0]   wavelength,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [sdi_pkg::RootWidth-1:0]        refractive_index,
  output logic [sdi_pkg::StatWidth-1:0]        status
);
  import sdi_pkg::*;

  logic en;
  logic [NumTerms-1:0][CoefWidth-1:0] strength, resonance;
  term_t [NumTerms-1:0]               term;
  logic                               term_valid;
  logic [NumTerms-1:0][NumWidth-1:0]  quot;
  logic [NumTerms-1:0]                quot_neg;
  logic                               quot_pole, quot_valid;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      strength  <= '0;
      resonance <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STRENGTH_ONE:    strength[0]  <= cfg_data;
        REG_STRENGTH_TWO:    strength[1]  <= cfg_data;
        REG_STRENGTH_THREE:  strength[2]  <= cfg_data;
        REG_RESONANCE_ONE:   resonance[0] <= cfg_data;
        REG_RESONANCE_TWO:   resonance[1] <= cfg_data;
        REG_RESONANCE_THREE: resonance[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  sdi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .wavelength (wavelength),
    .strength   (strength),
    .resonance  (resonance),
    .term       (term),
    .term_valid (term_valid)
  );

  sdi_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .term       (term),
    .term_valid (term_valid),
    .quot       (quot),
    .quot_neg   (quot_neg),
    .quot_pole  (quot_pole),
    .quot_valid (quot_valid)
  );

  sdi_root u_root (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .quot             (quot),
    .quot_neg         (quot_neg),
    .quot_pole        (quot_pole),
    .quot_valid       (quot_valid),
    .refractive_index (refractive_index),
    .status           (status),
    .out_valid        (out_valid)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sdi_checker.sv =====
// ----------------------------------------------------------------------------
// sdi_checker
// Port-level checks of the dispersion index block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sdi_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [sdi_pkg::RootWidth-1:0]   refractive_index,
  input wire logic [sdi_pkg::StatWidth-1:0]   status
);
  import sdi_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(refractive_index) && $stable(status))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_POLE || status == ST_NEG) |-> refractive_index == '0)
    else $error("index not zero on error");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_POLE || status == ST_NEG))
    else $error("bad status code");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input stalled without output stall");

endmodule

bind sellmeier_dispersion_index sdi_checker u_sdi_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .refractive_index (refractive_index),
  .status           (status)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for sellmeier_dispersion_index: writes coefficient sets
// between phases, streams wavelengths through the valid/ready input with
// random gaps, and checks each index and status against a bit-exact
// fixed-point Sellmeier predictor, with random and long output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import sdi_pkg::*;

  typedef struct packed {
    logic [RootWidth-1:0] index;
    logic [StatWidth-1:0] stat;
  } index_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [IndexWidth-1:0] cfg_index = '0;
  logic [CoefWidth-1:0]  cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [WaveWidth-1:0]  wavelength = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [RootWidth-1:0]  refractive_index;
  logic [StatWidth-1:0]  status;

  logic [CoefWidth-1:0]  coef [0:5];
  logic [WaveWidth-1:0]  wave_q [$];
  index_result_t         index_q [$];
  int                    mismatches = 0;
  int                    accepted = 0;
  int                    send_gap = 0;
  int                    recv_gap = 0;
  int                    hold_left = 0;
  bit                    hold_done = 0;
  bit                    calm = 0;

  sellmeier_dispersion_index u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .wavelength(wavelength),
    .out_valid(out_valid), .out_ready(out_ready),
    .refractive_index(refractive_index), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] isqrt64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  function automatic index_result_t sellmeier_index(logic [WaveWidth-1:0] w);
    logic [47:0]  l2;
    logic [63:0]  bs, cs, d, bmag, dmag;
    logic [127:0] acc, num, q;
    index_result_t r;
    l2 = {24'd0, w} * {24'd0, w};
    acc = 128'd1 << 40;
    for (int i = 0; i < NumTerms; i++) begin
      bs = {{32{coef[i][31]}}, coef[i]};
      cs = {{32{coef[i+3][31]}}, coef[i+3]};
      d = {16'd0, l2} - (cs << 18);
      if (d == 0) begin
        r.index = '0;
        r.stat = ST_POLE;
        return r;
      end
      bmag = bs[63] ? -bs : bs;
      dmag = d[63] ? -d : d;
      num = ({64'd0, bmag} * {80'd0, l2}) << 12;
      q = num / {64'd0, dmag};
      if (bs[63] != d[63]) q = -q;
      acc = acc + q;
    end
    if (acc[127]) begin
      r.index = '0;
      r.stat = ST_NEG;
    end else if (acc >= (128'd1 << 48)) begin
      r.index = '1;
      r.stat = ST_OK;
    end else begin
      r.index = isqrt64(acc[63:0] << 16);
      r.stat = ST_OK;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic write_coef(logic [IndexWidth-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic load_set(logic [31:0] b1, b2, b3, c1, c2, c3);
    write_coef(REG_STRENGTH_ONE, b1);
    write_coef(REG_STRENGTH_TWO, b2);
    write_coef(REG_STRENGTH_THREE, b3);
    write_coef(REG_RESONANCE_ONE, c1);
    write_coef(REG_RESONANCE_TWO, c2);
    write_coef(REG_RESONANCE_THREE, c3);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    wait (wave_q.size() == 0 && !in_valid && index_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // pick a wavelength: mostly optical band, some full range, some at or near poles
  function automatic logic [WaveWidth-1:0] pick_wave();
    int sel;
    logic [15:0] k;
    sel = $urandom_range(0, 9);
    if (sel < 6) return WaveWidth'($urandom_range(24'h04CCCC, 24'h280000));
    if (sel < 8) return WaveWidth'($urandom);
    k = 16'(isqrt64({32'd0, coef[3 + $urandom_range(0, 2)]}));
    return WaveWidth'({k, 9'd0});
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (wave_q.size() > 0) begin
        in_valid   <= 1'b1;
        wavelength <= wave_q.pop_front();
        if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && accepted >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap  <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    index_result_t want;
    if (!rst) begin
      if (cfg_write && cfg_index <= REG_RESONANCE_THREE) coef[cfg_index] = cfg_data;
      if (in_valid && in_ready) begin
        index_q.push_back(sellmeier_index(wavelength));
        accepted++;
      end
      if (out_valid && out_ready) begin
        if (index_q.size() == 0) begin
          report_mismatch("unexpected transfer", refractive_index, 0);
        end else begin
          want = index_q.pop_front();
          if (refractive_index !== want.index)
            report_mismatch("refractive_index", refractive_index, want.index);
          if (status !== want.stat)
            report_mismatch("status", 32'(status), 32'(want.stat));
        end
      end
    end
  end

  initial begin
    logic [15:0] k;
    logic [WaveWidth-1:0] corner_waves [9];
    for (int i = 0; i < 6; i++) coef[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients: every term is a pole at zero wavelength
    wave_q.push_back(24'h000000);
    wave_q.push_back(24'h100000);
    drain();

    // glass-like set and writes to unused indices, then directed extremes
    load_set(32'h10A2_E900, 32'h03C1_0A00, 32'h1038_3A00,
             32'h0000_6263, 32'h0005_2000, 32'h1A1A_0000);
    write_coef(3'd6, 32'hDEAD_BEEF);
    write_coef(3'd7, 32'h1234_5678);
    @(posedge clk);
    cfg_write <= 1'b0;
    corner_waves = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'hAAAAAA, 24'h555555,
                     24'h080000, 24'h0A0000, 24'h180000, 24'h100000};
    foreach (corner_waves[j]) wave_q.push_back(corner_waves[j]);
    drain();

    // exact pole on term two, negative radicand, saturation
    load_set(32'h1000_0000, 32'h1000_0000, 32'h0, 32'h0, 32'h0000_0400, 32'h0);
    wave_q.push_back(24'h004000);
    wave_q.push_back(24'h004001);
    drain();
    load_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    wave_q.push_back(24'h100000);
    wave_q.push_back(24'hFFFFFF);
    drain();
    load_set(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    wave_q.push_back(24'h100000);
    wave_q.push_back(24'hFFFFFF);
    wave_q.push_back(24'h000001);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 7) calm = 1;
      k = 16'($urandom_range(1, 16'h7FFF));
      case (p % 4)
        0: load_set($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: load_set($urandom_range(0, 32'h2000_0000), $urandom_range(0, 32'h1000_0000),
                    $urandom_range(0, 32'h2000_0000), $urandom_range(0, 32'h0004_0000),
                    $urandom_range(0, 32'h0040_0000), 32'(k[9:0]) * 32'(k[9:0]));
        2: load_set(32'h8000_0000 | $urandom, $urandom_range(0, 32'h1000_0000), $urandom,
                    32'(k) * 32'(k), $urandom_range(0, 32'h0100_0000), $urandom);
        default: load_set($urandom_range(0, 32'h2000_0000), $urandom, 32'h7FFF_FFFF,
                          $urandom, 32'(k[11:0]) * 32'(k[11:0]), 32'h8000_0000);
      endcase
      for (int j = 0; j < 180; j++) wave_q.push_back(pick_wave());
      drain();
    end

    repeat (150) @(posedge clk);
    if (mismatches == 0 && index_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
